FILE: rtl/lgrs_pkg.sv
// ----------------------------------------------------------------------------
// Life generation row stream package
// Shared widths, the job record passed from front to back, and the B3/S23
// cell rule applied across a whole row.
// ----------------------------------------------------------------------------
package lgrs_pkg;

	// Grid geometry.
	localparam int MAX_COLUMNS = 64;
	localparam int ROW_W       = 64;
	localparam int COL_W       = 7;
	localparam int CNT_W       = 4;

	// Queue geometry.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [COL_W-1:0] cols_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	// Rule thresholds.
	localparam cnt_t BIRTH_COUNT = cnt_t'(3);
	localparam cnt_t SURVIVE_LOW = cnt_t'(2);

	// One unit of work for the back part. A paired job yields two results:
	// the middle row against its neighbours, then the final row on a dead
	// border.
	typedef struct packed {
		row_t above;
		row_t here;
		row_t below;
		logic pair;
		logic done;
	} job_t;

	// Mask of the columns in use; zero counts as one, anything above the
	// maximum counts as the maximum.
	function automatic row_t col_mask(cols_t cols);
		cols_t eff;
		row_t  m;
		eff = cols;
		if (eff == cols_t'(0)) begin
			eff = cols_t'(1);
		end
		if (eff > cols_t'(MAX_COLUMNS)) begin
			eff = cols_t'(MAX_COLUMNS);
		end
		for (int j = 0; j < ROW_W; j++) begin
			m[j] = (cols_t'(j) < eff);
		end
		return m;
	endfunction

	localparam row_t RESET_MASK = col_mask(cols_t'(MAX_COLUMNS));

	// One generation of a row given its two neighbour rows.
	function automatic row_t evolve(row_t above, row_t here, row_t below, row_t mask);
		row_t a;
		row_t h;
		row_t b;
		row_t a_l;
		row_t a_r;
		row_t h_l;
		row_t h_r;
		row_t b_l;
		row_t b_r;
		row_t r;
		cnt_t cnt;
		a   = above & mask;
		h   = here & mask;
		b   = below & mask;
		a_l = a << 1;
		a_r = a >> 1;
		h_l = h << 1;
		h_r = h >> 1;
		b_l = b << 1;
		b_r = b >> 1;
		for (int j = 0; j < ROW_W; j++) begin
			cnt = cnt_t'(a[j]) + cnt_t'(a_l[j]) + cnt_t'(a_r[j]) + cnt_t'(h_l[j])
				+ cnt_t'(h_r[j]) + cnt_t'(b[j]) + cnt_t'(b_l[j]) + cnt_t'(b_r[j]);
			r[j] = (cnt == BIRTH_COUNT) || (h[j] && (cnt == SURVIVE_LOW));
		end
		return r & mask;
	endfunction

endpackage

FILE: rtl/lgrs_front.sv
// ----------------------------------------------------------------------------
// Life generation front part
// Accepts row requests, keeps the two previous rows and turns each row into
// a job for the back part, or into nothing for the first row of a grid.
// ----------------------------------------------------------------------------
module lgrs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  lgrs_pkg::row_t mask,
	input  logic          in_valid,
	output logic          in_stall,
	input  lgrs_pkg::row_t row_cells,
	input  logic          final_row,
	input  logic          q_full,
	output logic          push,
	output lgrs_pkg::job_t push_job
);

	lgrs_pkg::row_t older_q;
	lgrs_pkg::row_t middle_q;
	logic [1:0]     held_q;
	logic           accept;

	// The queue is the only thing that holds the input back.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Classify the row: the first row of a grid only makes a job when it is
	// also the last one.
	always_comb begin
		push_job = '0;
		if (held_q == 2'd0) begin
			push_job.above = '0;
			push_job.here  = row_cells;
			push_job.below = '0;
			push_job.pair  = 1'b0;
			push_job.done  = 1'b1;
			push          = accept && final_row;
		end else begin
			push_job.above = older_q;
			push_job.here  = middle_q;
			push_job.below = row_cells;
			push_job.pair  = final_row;
			push_job.done  = 1'b0;
			push          = accept;
		end
	end

	// Row history; the final row starts a fresh grid. A held row keeps only
	// the columns in use when it arrived.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= '0;
			middle_q <= '0;
			held_q   <= 2'd0;
		end else if (accept) begin
			if (final_row) begin
				older_q  <= '0;
				middle_q <= '0;
				held_q   <= 2'd0;
			end else begin
				older_q  <= (held_q == 2'd0) ? '0 : middle_q;
				middle_q <= row_cells & mask;
				held_q   <= (held_q >= 2'd1) ? 2'd2 : 2'd1;
			end
		end
	end

endmodule

FILE: rtl/lgrs_queue.sv
// ----------------------------------------------------------------------------
// Life generation job queue
// Two-entry first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module lgrs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lgrs_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output lgrs_pkg::job_t head
);

	lgrs_pkg::job_t              slot_q [lgrs_pkg::QDEPTH];
	logic [lgrs_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lgrs_pkg::QPTR_W-1:0] rd_ptr_q;
	lgrs_pkg::qcnt_t             count_q;

	assign full  = (count_q == lgrs_pkg::qcnt_t'(lgrs_pkg::QDEPTH));
	assign empty = (count_q == lgrs_pkg::qcnt_t'(0));
	assign head  = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/lgrs_back.sv
// ----------------------------------------------------------------------------
// Life generation back part
// Takes jobs from the queue, applies the cell rule and holds each result
// row in an output register until it is taken.
// ----------------------------------------------------------------------------
module lgrs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  lgrs_pkg::row_t mask,
	input  logic           q_empty,
	input  lgrs_pkg::job_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output lgrs_pkg::row_t next_row_cells,
	output logic           grid_done
);

	logic           out_valid_q;
	logic           phase_q;
	lgrs_pkg::row_t result_q;
	logic           done_q;
	logic           load;
	lgrs_pkg::row_t sel_above;
	lgrs_pkg::row_t sel_here;
	lgrs_pkg::row_t sel_below;
	logic           sel_done;
	lgrs_pkg::row_t result_d;

	// A new result may enter the output register when it is empty or drains.
	assign load = !q_empty && (!out_valid_q || !out_stall);
	assign pop  = load && (!head.pair || phase_q);

	// The second half of a paired job evolves the final row on a dead border.
	always_comb begin
		if (phase_q) begin
			sel_above = head.here;
			sel_here  = head.below;
			sel_below = '0;
			sel_done  = 1'b1;
		end else begin
			sel_above = head.above;
			sel_here  = head.here;
			sel_below = head.below;
			sel_done  = head.pair ? 1'b0 : head.done;
		end
	end

	assign result_d = lgrs_pkg::evolve(sel_above, sel_here, sel_below, mask);

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
			done_q   <= sel_done;
		end
	end

	// Output valid and pair phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= head.pair && !phase_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign next_row_cells = result_q;
	assign grid_done      = done_q;

endmodule

FILE: rtl/life_generation_row_stream.sv
// ----------------------------------------------------------------------------
// Life generation row stream
// One B3/S23 generation over a dead-bordered grid, one row per request.
// A result passes through the job queue and the output register after the
// row request that completes it is accepted; the second result of a final
// row follows from the same job. The input takes one row per cycle while
// neither the two-entry job queue nor out_stall holds it back, and the rule
// evaluation is combinational; a final row with two results uses the back
// part for both of them. Reset clears the row history, queue and output
// valid, and sets the column count to 64; there is no clearing pass.
// ----------------------------------------------------------------------------
module life_generation_row_stream (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  lgrs_pkg::cols_t       cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lgrs_pkg::row_t        row_cells,
	input  logic                  final_row,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lgrs_pkg::row_t        next_row_cells,
	output logic                  grid_done
);

	lgrs_pkg::row_t mask_q;
	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	lgrs_pkg::job_t push_job;
	lgrs_pkg::job_t head;

	// Column count is kept as its decoded mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= lgrs_pkg::RESET_MASK;
		end else if (cfg_write) begin
			mask_q <= lgrs_pkg::col_mask(cfg_data);
		end
	end

	lgrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mask      (mask_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.row_cells (row_cells),
		.final_row (final_row),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	lgrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	lgrs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.mask           (mask_q),
		.q_empty        (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_row_cells (next_row_cells),
		.grid_done      (grid_done)
	);

endmodule

FILE: rtl/lgrs_checker.sv
// ----------------------------------------------------------------------------
// Life generation port checker
// Watches the top-level ports for reset behaviour, result latency and
// output holding under stall.
// ----------------------------------------------------------------------------
module lgrs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input lgrs_pkg::row_t  next_row_cells,
	input logic            grid_done
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_row_cells) && $stable(grid_done))
		else $error("stalled result changed");

	// An idle output only wakes up after an accepted row request, through the job queue and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching request");

	// Nothing is presented in the cycle after reset.
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid straight after reset");

	// The queue is empty just after reset, so the input is not held off.
	assert property (@(posedge clk) !arst_n |=> !in_stall)
		else $error("input stalled straight after reset");

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (.*);
